// ----- rtl/wcfc_pkg.sv -----
`timescale 1ns / 1ps

package wcfc_pkg;

	// Frame layout: payload bytes first, then a little-endian check word.
	localparam int FRAME_BYTES   = 16;
	localparam int CHECK_BYTES   = 4;
	localparam int PAYLOAD_BYTES = FRAME_BYTES - CHECK_BYTES;

	localparam int POS_W  = 4;
	localparam int SUM_W  = 12;
	localparam int BSUM_W = 6;
	localparam int WGT_W  = 9;
	localparam int WORD_W = 32;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [WGT_W-1:0]  wgt_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam pos_t LAST_POS = pos_t'(FRAME_BYTES - 1);
	localparam pos_t PAY_END  = pos_t'(PAYLOAD_BYTES);

	// One finished frame as it is handed to the output register.
	typedef struct packed {
		logic  frame_ok;
		word_t first_word;
		word_t second_word;
		word_t third_word;
		sum_t  computed_sum;
		word_t received_sum;
	} res_t;

	// Sum of (b+1) over the set bits b of one byte.
	function automatic logic [BSUM_W-1:0] bit_sum(input logic [7:0] v);
		logic [BSUM_W-1:0] acc;
		acc = '0;
		for (int b = 0; b < 8; b++) begin
			if (v[b]) begin
				acc = acc + BSUM_W'(b + 1);
			end
		end
		return acc;
	endfunction

endpackage

// ----- rtl/wcfc_weight.sv -----
`timescale 1ns / 1ps

module wcfc_weight (
	input  logic [7:0]         data,
	input  wcfc_pkg::pos_t     pos,
	output wcfc_pkg::wgt_t     weight
);
	import wcfc_pkg::*;

	logic [BSUM_W-1:0]      bsum;
	logic [POS_W-1:0]       factor;
	logic [BSUM_W+POS_W-1:0] prod;

	// Bit weights of the byte, scaled by its one-based position in the frame.
	always_comb begin
		bsum   = bit_sum(data);
		factor = pos + 1'b1;
		prod   = (BSUM_W+POS_W)'(bsum) * (BSUM_W+POS_W)'(factor);
		weight = prod[WGT_W-1:0];
	end

endmodule

// ----- rtl/wcfc_frame.sv -----
`timescale 1ns / 1ps

module wcfc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data,
	output logic              res_valid,
	output wcfc_pkg::res_t    res
);
	import wcfc_pkg::*;

	pos_t       pos_q;
	sum_t       sum_q;
	logic       skip_q;
	logic [7:0] store_q [PAYLOAD_BYTES];
	word_t      check_q;

	wgt_t       weight;
	logic       is_payload;
	logic       is_last;
	word_t      check_next;

	wcfc_weight u_weight (
		.data   (data),
		.pos    (pos_q),
		.weight (weight)
	);

	// Decode the position and merge the incoming byte into the check word.
	always_comb begin
		is_payload = (pos_q < PAY_END);
		is_last    = (pos_q == LAST_POS);
		check_next = check_q;
		case (pos_q[1:0])
			2'd0:    check_next[7:0]   = data;
			2'd1:    check_next[15:8]  = data;
			2'd2:    check_next[23:16] = data;
			default: check_next[31:24] = data;
		endcase
	end

	// Result fields for the frame that completes with this byte.
	always_comb begin
		res.frame_ok     = ({{(WORD_W-SUM_W){1'b0}}, sum_q} == check_next);
		res.first_word   = {store_q[3], store_q[2], store_q[1], store_q[0]};
		res.second_word  = {store_q[7], store_q[6], store_q[5], store_q[4]};
		res.third_word   = {store_q[11], store_q[10], store_q[9], store_q[8]};
		res.computed_sum = sum_q;
		res.received_sum = check_next;
		res_valid        = step && !skip_q && is_last;
	end

	// Frame control: position, running sum and the slip after a mismatch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			skip_q <= 1'b0;
		end else if (step) begin
			if (skip_q) begin
				skip_q <= 1'b0;
				pos_q  <= '0;
			end else if (is_payload) begin
				sum_q <= sum_q + SUM_W'(weight);
				pos_q <= pos_q + 1'b1;
			end else if (is_last) begin
				pos_q  <= '0;
				sum_q  <= '0;
				skip_q <= !res.frame_ok;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Payload bytes and the check word hold data only.
	always_ff @(posedge clk) begin
		if (step && !skip_q) begin
			if (is_payload) begin
				store_q[pos_q] <= data;
			end else begin
				check_q <= check_next;
			end
		end
	end

endmodule

// ----- rtl/weighted_checksum_frame_checker_core.sv -----
`timescale 1ns / 1ps
// Path: the last byte of a frame passes the input register, then the result register, which
// offers the frame's result until it is taken.
// Throughput: one byte per cycle while results are taken; a held result lets one more
// request into the input register and then stalls the input until the result is taken.
// Reset: arst_n clears the frame position, running sum, slip flag and both valid bits;
// payload bytes and the check word are written before they are read and need no reset.
module weighted_checksum_frame_checker_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                frame_ok,
	output wcfc_pkg::word_t     first_word,
	output wcfc_pkg::word_t     second_word,
	output wcfc_pkg::word_t     third_word,
	output wcfc_pkg::sum_t      computed_sum,
	output wcfc_pkg::word_t     received_sum
);
	import wcfc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       res_valid;
	res_t       res;
	logic       valid_q;
	res_t       res_q;

	// The byte stage moves on whenever the result register can take a request.
	always_comb begin
		out_free = !valid_q || !out_stall;
		step     = valid_s1 && out_free;
		in_stall = valid_s1 && !out_free;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	wcfc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data      (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign frame_ok     = res_q.frame_ok;
	assign first_word   = res_q.first_word;
	assign second_word  = res_q.second_word;
	assign third_word   = res_q.third_word;
	assign computed_sum = res_q.computed_sum;
	assign received_sum = res_q.received_sum;

endmodule

// ----- rtl/wcfc_checker.sv -----
`timescale 1ns / 1ps

module wcfc_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                frame_ok,
	input  wcfc_pkg::sum_t      computed_sum,
	input  wcfc_pkg::word_t     received_sum
);
	import wcfc_pkg::*;

	// A stalled result request stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result request dropped while stalled");

	// The match flag agrees with the two sums it reports.
	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_ok == ({{(WORD_W-SUM_W){1'b0}}, computed_sum} == received_sum)))
		else $error("frame_ok disagrees with the reported sums");

	// The weighted payload sum stays within its bound.
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (computed_sum <= SUM_W'(2808)))
		else $error("computed_sum beyond its bound");

	// Input back-pressure only comes from a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

endmodule

bind weighted_checksum_frame_checker_core wcfc_checker u_wcfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.frame_ok     (frame_ok),
	.computed_sum (computed_sum),
	.received_sum (received_sum)
);
